@@ hdl/rrp_pkg.sv @@
package rrp_pkg;

  localparam int SPAN_W = 47;  // region span and working radius
  localparam int ADDR_W = 64;  // region address
  localparam int LD_W   = 48;  // difference of two normalized local offsets
  localparam int D_W    = 50;  // signed relative axis before the radius check
  localparam int EXT_W  = 66;  // common width for signed compares
  localparam int OUT_W  = 48;  // result fields

  // register index on the config port
  localparam logic REG_SPAN   = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OVF    = 2'd1,
    ST_RADIUS = 2'd2
  } status_e;

  function automatic logic out_of_radius(input logic signed [EXT_W-1:0] v,
                                         input logic [SPAN_W-1:0] r);
    logic signed [EXT_W-1:0] rs;
    rs = $signed({{(EXT_W-SPAN_W){1'b0}}, r});
    return (v > rs) || (v < -rs);
  endfunction

endpackage

@@ hdl/rrp_delay.sv @@
module rrp_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

@@ hdl/rrp_div.sv @@
// Unsigned restoring divider, one quotient bit per stage.
module rrp_div #(
  parameter int W = 48
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [W-1:0]              dvd_i,
  input  logic [rrp_pkg::SPAN_W-1:0] span_i,
  output logic [W-1:0]              quo_o,
  output logic [rrp_pkg::SPAN_W-1:0] rem_o
);
  import rrp_pkg::*;

  logic [SPAN_W-1:0] rem_q [W];
  logic [W-1:0]      dvd_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [SPAN_W-1:0] rem_in;
    logic [W-1:0]      dvd_in;
    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   diff;
    logic              ge;
    logic [SPAN_W-1:0] rem_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dvd_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
    end

    assign trial = {rem_in, dvd_in[W-1]};
    assign ge    = trial >= {1'b0, span_i};
    assign diff  = trial - {1'b0, span_i};
    assign rem_d = ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        dvd_q[k] <= {dvd_in[W-2:0], ge};
      end
    end
  end

  assign quo_o = dvd_q[W-1];
  assign rem_o = rem_q[W-1];

endmodule

@@ hdl/rrp_rel_axis.sv @@
// Relative distance on one horizontal axis: (pa - oa) * span + ld.
// Seven register stages.
module rrp_rel_axis (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [rrp_pkg::SPAN_W-1:0]        span_i,
  input  logic [rrp_pkg::SPAN_W-1:0]        radius_i,
  input  logic signed [rrp_pkg::ADDR_W-1:0] pa_i,
  input  logic signed [rrp_pkg::ADDR_W-1:0] oa_i,
  input  logic signed [rrp_pkg::LD_W-1:0]   ld_i,
  output logic signed [rrp_pkg::D_W-1:0]    d_o,
  output logic                              fail_o
);
  import rrp_pkg::*;

  localparam int DIFF_W = ADDR_W + 1;
  localparam int HALF   = 24;
  localparam int P1_W   = 2 * SPAN_W;

  // stage 1: region difference
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [LD_W-1:0]   ld1_q;

  // stage 2: magnitude minus one
  logic [DIFF_W-1:0]  mm_d;
  logic [SPAN_W-1:0]  mm2_q;
  logic               neg2_q, zero2_q, big2_q;
  logic signed [LD_W-1:0] ld2_q;

  // stage 3: partial products
  logic [2*HALF-1:0]               pp00_q;
  logic [HALF+SPAN_W-HALF-1:0]     pp01_q;
  logic [HALF+SPAN_W-HALF-1:0]     pp10_q;
  logic [2*(SPAN_W-HALF)-1:0]      pp11_q;
  logic                            neg3_q, zero3_q, big3_q;
  logic signed [LD_W-1:0]          ld3_q;

  // stage 4: middle sum
  logic [SPAN_W:0]                 mid_q;
  logic [2*HALF-1:0]               pp00_4_q;
  logic [2*(SPAN_W-HALF)-1:0]      pp11_4_q;
  logic                            neg4_q, zero4_q, big4_q;
  logic signed [LD_W-1:0]          ld4_q;

  // stage 5: full product (|diff| - 1) * span
  logic [P1_W-1:0]                 p1_q;
  logic                            neg5_q, zero5_q, big5_q;
  logic signed [LD_W-1:0]          ld5_q;

  // stage 6: product check and |diff| * span
  logic [LD_W:0]                   p6_q;
  logic                            neg6_q, fail6_q;
  logic signed [LD_W-1:0]          ld6_q;

  // stage 7: signed result
  logic signed [D_W-1:0]           d7_q;
  logic                            fail7_q;

  logic [P1_W-1:0] p1_d;
  logic signed [D_W-1:0] ld_ext, p_ext;

  assign mm_d = diff_q[DIFF_W-1] ? ~diff_q : diff_q - DIFF_W'(1);
  assign p1_d = {pp11_4_q, {(2*HALF){1'b0}}}
              + P1_W'({mid_q, {HALF{1'b0}}})
              + P1_W'(pp00_4_q);
  assign ld_ext = {{(D_W-LD_W){ld6_q[LD_W-1]}}, ld6_q};
  assign p_ext  = {{(D_W-LD_W-1){1'b0}}, p6_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= {pa_i[ADDR_W-1], pa_i} - {oa_i[ADDR_W-1], oa_i};
      ld1_q   <= ld_i;

      neg2_q  <= diff_q[DIFF_W-1];
      zero2_q <= diff_q == '0;
      big2_q  <= |mm_d[DIFF_W-1:SPAN_W];
      mm2_q   <= mm_d[SPAN_W-1:0];
      ld2_q   <= ld1_q;

      pp00_q  <= mm2_q[HALF-1:0] * span_i[HALF-1:0];
      pp01_q  <= mm2_q[HALF-1:0] * span_i[SPAN_W-1:HALF];
      pp10_q  <= mm2_q[SPAN_W-1:HALF] * span_i[HALF-1:0];
      pp11_q  <= mm2_q[SPAN_W-1:HALF] * span_i[SPAN_W-1:HALF];
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
      big3_q  <= big2_q;
      ld3_q   <= ld2_q;

      mid_q    <= (SPAN_W+1)'(pp01_q) + (SPAN_W+1)'(pp10_q);
      pp00_4_q <= pp00_q;
      pp11_4_q <= pp11_q;
      neg4_q   <= neg3_q;
      zero4_q  <= zero3_q;
      big4_q   <= big3_q;
      ld4_q    <= ld3_q;

      p1_q    <= p1_d;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
      big5_q  <= big4_q;
      ld5_q   <= ld4_q;

      // when the check passes, p1 <= radius, so the low bits are exact
      fail6_q <= !zero5_q && (big5_q || (p1_q > P1_W'(radius_i)));
      p6_q    <= zero5_q ? '0 : {1'b0, p1_q[LD_W-1:0]} + (LD_W+1)'(span_i);
      neg6_q  <= neg5_q;
      ld6_q   <= ld5_q;

      d7_q    <= neg6_q ? ld_ext - p_ext : ld_ext + p_ext;
      fail7_q <= fail6_q;
    end
  end

  assign d_o    = d7_q;
  assign fail_o = fail7_q;

endmodule

@@ hdl/region_relative_position_core.sv @@
// Region-relative position. Each request carries a position and an origin,
// both as 64-bit region addresses on x/z plus signed Q32.16 local offsets on
// x/y/z. The core normalizes x/z of both (floor division of the local offset
// by region_span, remainder kept as the new offset), then returns the position
// relative to the origin in Q32.16. status: 0 ok, 1 region address overflow
// (also a zero region_span), 2 some axis beyond working_radius; all three
// axes read zero on error. Fully pipelined: one request per cycle unless the
// result side stalls; the pipeline is the bit-per-stage divider (LOCAL_BITS
// stages) plus normalize, multiply and check stages. A result-side stall
// freezes the whole pipeline; nothing is dropped or replayed. region_span and
// working_radius sit at byte addresses 0 and 8 of the 64-bit APB port; the
// user must write them only while the pipeline is empty (not enforced here).
module region_relative_position_core #(
  parameter int LOCAL_BITS = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,

  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic signed [63:0]     pos_region_x_i,
  input  logic signed [63:0]     pos_region_z_i,
  input  logic signed [LOCAL_BITS-1:0] pos_local_x_i,
  input  logic signed [LOCAL_BITS-1:0] pos_local_y_i,
  input  logic signed [LOCAL_BITS-1:0] pos_local_z_i,
  input  logic signed [63:0]     org_region_x_i,
  input  logic signed [63:0]     org_region_z_i,
  input  logic signed [LOCAL_BITS-1:0] org_local_x_i,
  input  logic signed [LOCAL_BITS-1:0] org_local_y_i,
  input  logic signed [LOCAL_BITS-1:0] org_local_z_i,

  output logic                   valid_o,
  input  logic                   stall_i,
  output logic signed [rrp_pkg::OUT_W-1:0] rel_x_o,
  output logic signed [rrp_pkg::OUT_W-1:0] rel_y_o,
  output logic signed [rrp_pkg::OUT_W-1:0] rel_z_o,
  output logic [1:0]             status_o
);
  import rrp_pkg::*;

  localparam int L       = LOCAL_BITS;
  localparam int QW      = L + 1;          // signed quotient
  localparam int SUM_W   = ADDR_W + 2;     // address + quotient
  localparam int AX_LAT  = 7;              // rrp_rel_axis latency
  localparam int DEPTH   = L + AX_LAT + 4; // s0, div, n1, n2, axis, out
  localparam int SB_W    = 4 * ADDR_W + 2 * L;
  localparam int YD_W    = 1 + QW;

  // ---------------- config registers ----------------
  logic [SPAN_W-1:0] span_q, radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q   <= SPAN_W'(16777216);
      radius_q <= SPAN_W'(16777216);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        REG_SPAN:   span_q   <= pwdata[SPAN_W-1:0];
        REG_RADIUS: radius_q <= pwdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_SPAN:   prdata = {{(64-SPAN_W){1'b0}}, span_q};
      REG_RADIUS: prdata = {{(64-SPAN_W){1'b0}}, radius_q};
      default:    prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // ---------------- pipeline control ----------------
  // All stages advance together; hold everything while the result is stalled.
  logic [DEPTH-1:0] vld_q;
  logic             en;

  assign en      = !(vld_q[DEPTH-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], valid_i};
    end
  end

  // ---------------- s0: magnitudes for the dividers ----------------
  // lanes: 0 pos x, 1 pos z, 2 org x, 3 org z
  logic signed [L-1:0]      loc_in  [4];
  logic signed [ADDR_W-1:0] reg_in  [4];
  logic [L-1:0]             mag_q   [4];
  logic [3:0]               sgn_q;
  logic signed [ADDR_W-1:0] reg_s0_q [4];
  logic signed [L-1:0]      ply_s0_q, oly_s0_q;

  assign loc_in[0] = pos_local_x_i;
  assign loc_in[1] = pos_local_z_i;
  assign loc_in[2] = org_local_x_i;
  assign loc_in[3] = org_local_z_i;
  assign reg_in[0] = pos_region_x_i;
  assign reg_in[1] = pos_region_z_i;
  assign reg_in[2] = org_region_x_i;
  assign reg_in[3] = org_region_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sgn_q[i]    <= loc_in[i][L-1];
        mag_q[i]    <= loc_in[i][L-1] ? -loc_in[i] : loc_in[i];
        reg_s0_q[i] <= reg_in[i];
      end
      ply_s0_q <= pos_local_y_i;
      oly_s0_q <= org_local_y_i;
    end
  end

  // ---------------- dividers: |local| / span ----------------
  logic [L-1:0]      quo  [4];
  logic [SPAN_W-1:0] rem  [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    rrp_div #(.W(L)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .dvd_i  (mag_q[i]),
      .span_i (span_q),
      .quo_o  (quo[i]),
      .rem_o  (rem[i])
    );
  end

  // side data lined up with the n1 stage
  logic [SB_W-1:0] sb_in, sb_out;
  logic signed [ADDR_W-1:0] reg_n1 [4];
  logic signed [L-1:0]      ply_n1, oly_n1;
  logic [3:0]               sgn_div;

  assign sb_in = {reg_s0_q[0], reg_s0_q[1], reg_s0_q[2], reg_s0_q[3],
                  ply_s0_q, oly_s0_q};

  rrp_delay #(.WIDTH(SB_W), .DEPTH(L + 1)) u_sb_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sb_in),
    .q_o   (sb_out)
  );

  assign {reg_n1[0], reg_n1[1], reg_n1[2], reg_n1[3], ply_n1, oly_n1} = sb_out;

  // signs are needed one stage earlier, at the divider output
  rrp_delay #(.WIDTH(4), .DEPTH(L)) u_sgn_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sgn_q),
    .q_o   (sgn_div)
  );

  // ---------------- n1: floor quotient and non-negative remainder ----------------
  logic signed [QW-1:0] q_q [4];
  logic [SPAN_W-1:0]    r_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (!sgn_div[i]) begin
          q_q[i] <= {1'b0, quo[i]};
          r_q[i] <= rem[i];
        end else if (rem[i] == '0) begin
          q_q[i] <= -{1'b0, quo[i]};
          r_q[i] <= '0;
        end else begin
          q_q[i] <= ~{1'b0, quo[i]};   // -q - 1
          r_q[i] <= span_q - rem[i];
        end
      end
    end
  end

  // ---------------- n2: address update, overflow, local differences ----------------
  logic signed [SUM_W-1:0]  sum [4];
  logic [3:0]               lane_ovf;
  logic signed [ADDR_W-1:0] na_q [4];
  logic                     ovf_q;
  logic signed [LD_W-1:0]   ldx_q, ldz_q;
  logic signed [QW-1:0]     dy_q;

  for (genvar i = 0; i < 4; i++) begin : g_norm
    assign sum[i] = {{2{reg_n1[i][ADDR_W-1]}}, reg_n1[i]}
                  + {{(SUM_W-QW){q_q[i][QW-1]}}, q_q[i]};
    assign lane_ovf[i] = !((sum[i][SUM_W-1:ADDR_W-1] == '0) ||
                           (sum[i][SUM_W-1:ADDR_W-1] == '1));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        na_q[i] <= sum[i][ADDR_W-1:0];
      end
      ovf_q <= (|lane_ovf) || (span_q == '0);
      ldx_q <= {1'b0, r_q[0]} - {1'b0, r_q[2]};
      ldz_q <= {1'b0, r_q[1]} - {1'b0, r_q[3]};
      dy_q  <= {ply_n1[L-1], ply_n1} - {oly_n1[L-1], oly_n1};
    end
  end

  // ---------------- axis units ----------------
  logic signed [D_W-1:0] dx, dz;
  logic                  fail_x, fail_z;

  rrp_rel_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .span_i   (span_q),
    .radius_i (radius_q),
    .pa_i     (na_q[0]),
    .oa_i     (na_q[2]),
    .ld_i     (ldx_q),
    .d_o      (dx),
    .fail_o   (fail_x)
  );

  rrp_rel_axis u_axis_z (
    .clk_i    (clk_i),
    .en_i     (en),
    .span_i   (span_q),
    .radius_i (radius_q),
    .pa_i     (na_q[1]),
    .oa_i     (na_q[3]),
    .ld_i     (ldz_q),
    .d_o      (dz),
    .fail_o   (fail_z)
  );

  logic [YD_W-1:0]      yd_out;
  logic                 ovf_ax;
  logic signed [QW-1:0] dy_ax;

  rrp_delay #(.WIDTH(YD_W), .DEPTH(AX_LAT)) u_y_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({ovf_q, dy_q}),
    .q_o   (yd_out)
  );
  assign {ovf_ax, dy_ax} = yd_out;

  // ---------------- output stage: radius checks and status ----------------
  logic signed [EXT_W-1:0] dx_ext, dy_ext, dz_ext;
  logic                    rad_fail;
  logic signed [OUT_W-1:0] rel_x_q, rel_y_q, rel_z_q;
  status_e                 status_q;

  assign dx_ext = {{(EXT_W-D_W){dx[D_W-1]}}, dx};
  assign dz_ext = {{(EXT_W-D_W){dz[D_W-1]}}, dz};
  assign dy_ext = {{(EXT_W-QW){dy_ax[QW-1]}}, dy_ax};

  assign rad_fail = fail_x || fail_z ||
                    out_of_radius(dx_ext, radius_q) ||
                    out_of_radius(dy_ext, radius_q) ||
                    out_of_radius(dz_ext, radius_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ovf_ax) begin
        status_q <= ST_OVF;
        rel_x_q  <= '0;
        rel_y_q  <= '0;
        rel_z_q  <= '0;
      end else if (rad_fail) begin
        status_q <= ST_RADIUS;
        rel_x_q  <= '0;
        rel_y_q  <= '0;
        rel_z_q  <= '0;
      end else begin
        status_q <= ST_OK;
        rel_x_q  <= dx_ext[OUT_W-1:0];
        rel_y_q  <= dy_ext[OUT_W-1:0];
        rel_z_q  <= dz_ext[OUT_W-1:0];
      end
    end
  end

  assign rel_x_o  = rel_x_q;
  assign rel_y_o  = rel_y_q;
  assign rel_z_o  = rel_z_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (rel_x_o == '0 && rel_y_o == '0 && rel_z_o == '0))
    else $error("error result with nonzero axis");

  a_ok_in_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_OK) |->
      (!out_of_radius(EXT_W'(rel_x_o), radius_q) &&
       !out_of_radius(EXT_W'(rel_z_o), radius_q)))
    else $error("ok result beyond working radius");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> vld_q[DEPTH-1])
    else $error("input stalled with empty output stage");

  a_zero_span_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && span_q == '0) |-> status_o == ST_OVF)
    else $error("zero span not flagged");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench;
  import rrp_pkg::*;

  localparam int LB = 48;               // local offset width of the instance
  localparam int LATENCY = LB + 11;     // pipeline depth of the core
  localparam int CYCLE_LIMIT = 400000;  // far above the slowest correct run

  typedef logic signed [127:0] wide_t;  // exact arithmetic, never overflows here
  localparam wide_t ADDR_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam wide_t ADDR_MIN = -ADDR_MAX - 1;
  localparam logic [SPAN_W-1:0] SPAN_TOP = {SPAN_W{1'b1}};
  localparam logic [SPAN_W-1:0] RESET_SPAN = 47'd16777216;

  // One request: a position and an origin.
  typedef struct packed {
    logic signed [63:0]   prx, prz;
    logic signed [LB-1:0] plx, ply, plz;
    logic signed [63:0]   orx, orz;
    logic signed [LB-1:0] olx, oly, olz;
  } place_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] rx, ry, rz;
    status_e                 st;
  } offset_t;

  typedef struct packed {
    place_t  req;
    logic    known;   // expectation typed into the table
    offset_t want;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  logic    valid_i = 1'b0;
  logic    stall_o;
  place_t  cur = '0;
  logic    cur_known = 1'b0;
  offset_t cur_want = '0;
  logic    valid_o;
  logic    stall_i = 1'b0;
  logic signed [OUT_W-1:0] rel_x_o, rel_y_o, rel_z_o;
  logic [1:0] status_o;

  region_relative_position_core #(.LOCAL_BITS(LB)) dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .valid_i, .stall_o,
    .pos_region_x_i(cur.prx), .pos_region_z_i(cur.prz),
    .pos_local_x_i(cur.plx), .pos_local_y_i(cur.ply), .pos_local_z_i(cur.plz),
    .org_region_x_i(cur.orx), .org_region_z_i(cur.orz),
    .org_local_x_i(cur.olx), .org_local_y_i(cur.oly), .org_local_z_i(cur.olz),
    .valid_o, .stall_i, .rel_x_o, .rel_y_o, .rel_z_o, .status_o
  );

  // Testbench copy of the two registers.
  logic [SPAN_W-1:0] span_q = RESET_SPAN;
  logic [SPAN_W-1:0] radius_q = RESET_SPAN;

  offset_t pending_offsets[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;    // no idling on either side

  // Floor-divide the local offset into the region address; 0 on overflow.
  function automatic bit fold_axis(inout wide_t addr, inout wide_t loc,
                                   input wide_t span);
    wide_t q, r;
    q = loc / span;
    r = loc - q * span;
    if (r < 0) begin
      q = q - 1;
      r = r + span;
    end
    addr = addr + q;
    loc = r;
    return (addr <= ADDR_MAX) && (addr >= ADDR_MIN);
  endfunction

  function automatic offset_t relative_offset(input place_t p,
                                              input logic [SPAN_W-1:0] span_v,
                                              input logic [SPAN_W-1:0] rad_v);
    offset_t o;
    wide_t   s, rad, prx, prz, plx, plz, orx, orz, olx, olz, dx, dy, dz;
    bit      ok;
    o = '{rx: '0, ry: '0, rz: '0, st: ST_OK};
    s = span_v;
    rad = rad_v;
    prx = p.prx; prz = p.prz; plx = p.plx; plz = p.plz;
    orx = p.orx; orz = p.orz; olx = p.olx; olz = p.olz;
    if (s == 0) begin
      o.st = ST_OVF;
      return o;
    end
    ok = fold_axis(prx, plx, s);
    ok = fold_axis(prz, plz, s) && ok;
    ok = fold_axis(orx, olx, s) && ok;
    ok = fold_axis(orz, olz, s) && ok;
    if (!ok) begin
      o.st = ST_OVF;
      return o;
    end
    // exact distances; a region gap too big for the radius shows up here too
    dx = (prx - orx) * s + plx - olx;
    dz = (prz - orz) * s + plz - olz;
    dy = wide_t'(p.ply) - wide_t'(p.oly);
    if (dx > rad || dx < -rad || dy > rad || dy < -rad || dz > rad || dz < -rad) begin
      o.st = ST_RADIUS;
      return o;
    end
    o.rx = dx[OUT_W-1:0];
    o.ry = dy[OUT_W-1:0];
    o.rz = dz[OUT_W-1:0];
    return o;
  endfunction

  // Scoreboard: check results first, then log the newly accepted request.
  always @(posedge clk_i) begin
    offset_t w;
    cycles <= cycles + 1;
    if (valid_o && !stall_i) begin
      if (pending_offsets.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        w = pending_offsets.pop_front();
        if (rel_x_o !== w.rx || rel_y_o !== w.ry || rel_z_o !== w.rz ||
            status_o !== w.st) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: want x=%0d y=%0d z=%0d st=%0d got x=%0d y=%0d z=%0d st=%0d",
                     w.rx, w.ry, w.rz, w.st, rel_x_o, rel_y_o, rel_z_o, status_o);
        end
      end
    end
    if (rst_ni && valid_i && !stall_o)
      pending_offsets.push_back(cur_known ? cur_want
                                          : relative_offset(cur, span_q, radius_q));
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side back-pressure in bursts, with calm stretches.
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (quiet) begin
      stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  task automatic send_request(input vector_t v);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    cur = v.req;
    cur_known = v.known;
    cur_want = v.want;
    valid_i = 1'b1;
    do @(posedge clk_i); while (stall_o);
  endtask

  task automatic drain;
    @(negedge clk_i);
    valid_i = 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_reg(input logic idx, input logic [SPAN_W-1:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = 64'(val);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_SPAN) span_q = val;
    else radius_q = val;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic logic signed [63:0] around(input logic [63:0] lim);
    logic [63:0] u;
    u = {$urandom, $urandom};
    return $signed(u % (2 * lim + 1)) - $signed(lim);
  endfunction

  // Mostly nearby position/origin pairs so results land inside the radius;
  // the rest is raw bit noise.
  function automatic vector_t random_vector;
    vector_t v;
    logic [63:0] lim, ylim;
    v = '0;
    v.req.orx = {$urandom, $urandom};
    v.req.orz = {$urandom, $urandom};
    v.req.oly = LB'({$urandom, $urandom});
    if ($urandom_range(0, 9) < 7) begin
      lim = (span_q == 0) ? 64'd16777216 : 64'(span_q) * 3;
      if (lim > 64'(SPAN_TOP)) lim = 64'(SPAN_TOP);
      ylim = (64'(radius_q) > 64'h3FFF_FFFF_FFFF) ? 64'h3FFF_FFFF_FFFF : 64'(radius_q);
      v.req.prx = v.req.orx + around(2);
      v.req.prz = v.req.orz + around(2);
      v.req.plx = LB'(around(lim));
      v.req.plz = LB'(around(lim));
      v.req.olx = LB'(around(lim));
      v.req.olz = LB'(around(lim));
      v.req.ply = v.req.oly + LB'(around(ylim + ylim / 8));
    end else begin
      v.req.prx = {$urandom, $urandom};
      v.req.prz = {$urandom, $urandom};
      v.req.plx = LB'({$urandom, $urandom});
      v.req.ply = LB'({$urandom, $urandom});
      v.req.plz = LB'({$urandom, $urandom});
      v.req.olx = LB'({$urandom, $urandom});
      v.req.olz = LB'({$urandom, $urandom});
    end
    return v;
  endfunction

  function automatic vector_t row(input place_t p, input logic known, input offset_t o);
    vector_t v;
    v.req = p;
    v.known = known;
    v.want = o;
    return v;
  endfunction

  localparam logic signed [63:0] RMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] RMIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [LB-1:0] LMAX = {1'b0, {(LB-1){1'b1}}};
  localparam logic signed [LB-1:0] LMIN = {1'b1, {(LB-1){1'b0}}};
  localparam logic signed [LB-1:0] ONE_REGION = 48'sd16777216;

  vector_t directed[$];
  place_t  z;
  offset_t zero_ok, zero_ovf, zero_rad, o;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] radius;
  } setting_t;
  setting_t settings[$];

  initial begin
    z = '0;
    zero_ok = '{rx: '0, ry: '0, rz: '0, st: ST_OK};
    zero_ovf = '{rx: '0, ry: '0, rz: '0, st: ST_OVF};
    zero_rad = '{rx: '0, ry: '0, rz: '0, st: ST_RADIUS};

    // Directed table at reset settings (span = radius = 256.0).
    directed.push_back(row(z, 1'b1, zero_ok));
    // y magnitude equal to the radius passes
    z = '0; z.ply = ONE_REGION;
    o = zero_ok; o.ry = ONE_REGION;
    directed.push_back(row(z, 1'b1, o));
    // one LSB beyond the radius fails
    z = '0; z.ply = ONE_REGION + 1;
    directed.push_back(row(z, 1'b1, zero_rad));
    // region address overflow on normalize, both directions
    z = '0; z.prx = RMAX; z.plx = ONE_REGION;
    directed.push_back(row(z, 1'b1, zero_ovf));
    z = '0; z.prx = RMIN; z.plx = -1;
    directed.push_back(row(z, 1'b1, zero_ovf));
    z = '0; z.orz = RMAX; z.olz = LMAX;
    directed.push_back(row(z, 1'b1, zero_ovf));
    // overflow wins over an out-of-radius y
    z = '0; z.prz = RMAX; z.plz = LMAX; z.ply = LMAX;
    directed.push_back(row(z, 1'b1, zero_ovf));
    // one region step on x, exactly at the radius
    z = '0; z.prx = 1;
    o = zero_ok; o.rx = ONE_REGION;
    directed.push_back(row(z, 1'b1, o));
    z = '0; z.plx = -1;
    o = zero_ok; o.rx = -1;
    directed.push_back(row(z, 1'b1, o));
    // far regions with no overflow
    z = '0; z.prx = RMAX; z.orx = RMIN;
    directed.push_back(row(z, 1'b1, zero_rad));
    z = '0; z.prz = RMIN; z.orz = RMAX;
    directed.push_back(row(z, 1'b1, zero_rad));
    // local extremes, checked by the predictor
    z = '0; z.plx = LMIN; z.olx = LMAX;
    directed.push_back(row(z, 1'b0, zero_ok));
    z = '0; z.ply = LMAX; z.oly = LMIN;
    directed.push_back(row(z, 1'b0, zero_ok));
    z = '0; z.plz = LMAX; z.olz = LMAX - 5;
    directed.push_back(row(z, 1'b0, zero_ok));
    z = '0; z.prx = -3; z.plx = 3 * ONE_REGION + 7; z.olz = -ONE_REGION / 2;
    directed.push_back(row(z, 1'b0, zero_ok));
    z = '0; z.prx = RMAX; z.orx = RMAX - 1; z.plx = -ONE_REGION; z.olx = 12345;
    directed.push_back(row(z, 1'b0, zero_ok));

    settings.push_back('{span: 47'd1, radius: 47'd1});
    settings.push_back('{span: SPAN_TOP, radius: SPAN_TOP});
    settings.push_back('{span: 47'd65536, radius: SPAN_TOP});
    settings.push_back('{span: SPAN_TOP, radius: 47'd1});
    settings.push_back('{span: 47'd0, radius: RESET_SPAN});      // zero span
    settings.push_back('{span: RESET_SPAN, radius: 47'd0});      // zero radius
    settings.push_back('{span: 47'($urandom_range(1, 1 << 30)),
                         radius: 47'({$urandom, $urandom})});
    settings.push_back('{span: 47'd3, radius: 47'd1000});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_request(directed[i]);
    repeat (60) send_request(random_vector());

    foreach (settings[k]) begin
      drain;
      write_reg(REG_SPAN, settings[k].span);
      write_reg(REG_RADIUS, settings[k].radius);
      repeat (65) send_request(random_vector());
    end

    // closing phase back at the reset values, no idling on either side
    drain;
    write_reg(REG_SPAN, RESET_SPAN);
    write_reg(REG_RADIUS, RESET_SPAN);
    quiet = 1'b1;
    repeat (100) send_request(random_vector());

    drain;
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0 && pending_offsets.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rrp_pkg.sv
hdl/rrp_delay.sv
hdl/rrp_div.sv
hdl/rrp_rel_axis.sv
hdl/region_relative_position_core.sv
tb/testbench.sv
